@@ src/vtzc_pkg.sv @@
// Package for the viewport tile zone classifier.
// Holds the shared types, constants and the per-tile helper functions.
// Used by vtzc_div and by viewport_tile_zone_classifier_unit.
package vtzc_pkg;

    // Width of the grid count registers and of grid arithmetic.
    localparam int CNT_W = 4;
    localparam int RAD_W = 2;
    localparam int PITCH_W = 14;
    localparam int YAW_W = 15;
    localparam int MAG_W = 16;
    localparam int HALF_W = 3;
    localparam int NUM_W = 18;
    localparam int QUO_W = 5;
    localparam int BIT_W = 3;
    localparam int STEP_W = 14;
    localparam int NUMBER_W = 7;
    localparam int ZONE_W = 2;
    localparam int CFG_IDX_W = 2;

    // Quarter turn and half turn in units of 2^-12 radian.
    localparam logic [STEP_W-1:0] PITCH_STEP = STEP_W'(6431);
    localparam logic [STEP_W-1:0] YAW_STEP = STEP_W'(12861);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADJ_RADIUS = 2'd2;

    localparam logic [ZONE_W-1:0] ZONE_VIEW = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_ADJ = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_OUT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PITCH,
        ST_YAW,
        ST_SCAN
    } t_state;

    typedef enum logic {
        SEL_PITCH,
        SEL_YAW
    } t_step_sel;

    // Grid position from a quotient: a positive angle counts up from zero,
    // any other angle counts back from the last index. Clamped into the grid.
    function automatic logic [CNT_W-1:0] grid_pos(input logic [QUO_W-1:0] idx,
                                                  input logic positive,
                                                  input logic [CNT_W-1:0] count);
        logic [QUO_W-1:0] cnt_x;
        logic [QUO_W-1:0] last_x;
        logic [QUO_W-1:0] res;
        cnt_x = QUO_W'(count);
        last_x = cnt_x - QUO_W'(1);
        if (positive) begin
            res = (idx >= cnt_x) ? last_x : idx;
        end else begin
            res = (idx >= last_x) ? '0 : (last_x - idx);
        end
        return res[CNT_W-1:0];
    endfunction

    // Zone of one tile given its wrapped offsets from the viewport tile.
    function automatic logic [ZONE_W-1:0] tile_zone(input logic [CNT_W-1:0] r,
                                                    input logic [CNT_W-1:0] c,
                                                    input logic [CNT_W-1:0] vr,
                                                    input logic [CNT_W-1:0] vc,
                                                    input logic [CNT_W-1:0] rows,
                                                    input logic [CNT_W-1:0] cols,
                                                    input logic [RAD_W-1:0] rad);
        logic [CNT_W-1:0] dr;
        logic [CNT_W-1:0] dc;
        logic [CNT_W-1:0] dr_back;
        logic [CNT_W-1:0] dc_back;
        logic [CNT_W-1:0] rad_x;
        logic hit;
        dr = (r >= vr) ? (r - vr) : (r + rows - vr);
        dc = (c >= vc) ? (c - vc) : (c + cols - vc);
        dr_back = rows - dr;
        dc_back = cols - dc;
        rad_x = CNT_W'(rad);
        if (dr == '0 && dc == '0) begin
            return ZONE_VIEW;
        end
        if (dr == '0) begin
            hit = (dc <= rad_x) || (dc_back <= rad_x);
        end else if (dc == '0) begin
            hit = (dr <= rad_x) || (dr_back <= rad_x);
        end else begin
            // Diagonal: both offsets must use the same ray distance.
            hit = ((dr == dc) && (dr <= rad_x)) ||
                  ((dr == dc_back) && (dr <= rad_x)) ||
                  ((dr_back == dc) && (dc <= rad_x)) ||
                  ((dr_back == dc_back) && (dr_back <= rad_x));
        end
        return hit ? ZONE_ADJ : ZONE_OUT;
    endfunction

endpackage

@@ src/vtzc_div.sv @@
// Shared divider of the viewport tile zone classifier.
// Scales an angle magnitude by half the tile count and divides by a constant
// angle step, removing one step per cycle until the first borrow. Uses vtzc_pkg.
module vtzc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vtzc_pkg::MAG_W-1:0]    i_mag,
    input  logic [vtzc_pkg::HALF_W-1:0]   i_half,
    input  vtzc_pkg::t_step_sel           i_sel,
    output logic                          o_done,
    output logic [vtzc_pkg::QUO_W-1:0]    o_quo
);

    localparam int NUM_W = vtzc_pkg::NUM_W;

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [NUM_W-1:0]              r_rem, n_rem;
    logic [vtzc_pkg::QUO_W-1:0]    r_quo, n_quo;
    logic [vtzc_pkg::STEP_W-1:0]   r_step, n_step;
    logic [NUM_W:0]                w_diff;
    logic [NUM_W-1:0]              w_prod;

    // The largest product, 16384 times 7, fits the numerator width.
    assign w_prod = NUM_W'(i_mag) * NUM_W'(i_half);
    assign w_diff = {1'b0, r_rem} - (NUM_W + 1)'(r_step);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_rem  = w_prod;
            n_quo  = '0;
            n_step = (i_sel == vtzc_pkg::SEL_PITCH) ? vtzc_pkg::PITCH_STEP
                                                    : vtzc_pkg::YAW_STEP;
        end else if (r_busy) begin
            // The top bit of the difference is the borrow, which ends the division.
            if (w_diff[NUM_W]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_rem = w_diff[NUM_W-1:0];
                n_quo = r_quo + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |=> !(r_busy && r_done))
        else $error("divider busy and done together");

endmodule

@@ src/viewport_tile_zone_classifier_unit.sv @@
// Viewport tile zone classifier: top level with sequencer, tile scan and output register.
// Depends on vtzc_pkg and vtzc_div.
//
// Each accepted orientation (pitch, yaw) is mapped to a viewport tile of a
// rows-by-cols grid, and then every tile is sent in raster order with its
// number, its zone (0 viewport, 1 adjacency ring, 2 outside) and tlast on the
// final tile. The two grid positions come from one shared compare-and-subtract
// divider that removes one angle step per cycle and stops at the first borrow,
// first for pitch, then for yaw. Then the tiles follow at one per cycle while
// the output side is ready, and the input is not ready until the last tile
// has been loaded. Grid size and radius are written through the configuration
// port; the user must write them only while the block is idle, which the block
// itself does not enforce.
module viewport_tile_zone_classifier_unit #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // Orientation input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [13:0] pitch_angle, [28:14] yaw_angle, [31:29] zero
    // Tile output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] tile_number, [8:7] tile_zone, [15:9] zero
    output logic        m_tlast    // last_tile
);

    localparam int CNT_W = vtzc_pkg::CNT_W;
    localparam int RW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;

    vtzc_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]            r_grid_rows;
    logic [CNT_W-1:0]            r_grid_cols;
    logic [vtzc_pkg::RAD_W-1:0]  r_adj_radius;

    logic [CNT_W-1:0]            w_rows;
    logic [CNT_W-1:0]            w_cols;
    logic [CNT_W-1:0]            w_lim;
    logic [vtzc_pkg::RAD_W-1:0]  w_rad;

    logic [vtzc_pkg::PITCH_W-1:0] w_pitch;
    logic [vtzc_pkg::YAW_W-1:0]   w_yaw;
    logic [vtzc_pkg::MAG_W-1:0]   w_pitch_mag;
    logic [vtzc_pkg::MAG_W-1:0]   w_yaw_mag;
    logic                         w_pitch_pos;
    logic                         w_yaw_pos;
    logic                         w_in_acc;
    logic                         w_out_free;

    logic [vtzc_pkg::MAG_W-1:0]  r_yaw_mag, n_yaw_mag;
    logic                        r_pitch_pos, n_pitch_pos;
    logic                        r_yaw_pos, n_yaw_pos;
    logic [RW-1:0]               r_view_row, n_view_row;
    logic [CW-1:0]               r_view_col, n_view_col;
    logic [RW-1:0]               r_scan_row, n_scan_row;
    logic [CW-1:0]               r_scan_col, n_scan_col;
    logic [vtzc_pkg::NUMBER_W-1:0] r_num, n_num;
    logic                        w_scan_last_col;
    logic                        w_scan_last_row;

    logic                          r_m_tvalid, n_m_tvalid;
    logic [vtzc_pkg::NUMBER_W-1:0] r_m_number, n_m_number;
    logic [vtzc_pkg::ZONE_W-1:0]   r_m_zone, n_m_zone;
    logic                          r_m_last, n_m_last;

    logic                          w_div_start;
    logic [vtzc_pkg::MAG_W-1:0]    w_div_mag;
    logic [vtzc_pkg::HALF_W-1:0]   w_div_half;
    vtzc_pkg::t_step_sel           w_div_sel;
    logic                          w_div_done;
    logic [vtzc_pkg::QUO_W-1:0]    w_div_quo;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= CNT_W'(4);
            r_grid_cols  <= CNT_W'(8);
            r_adj_radius <= vtzc_pkg::RAD_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vtzc_pkg::REG_GRID_ROWS:  r_grid_rows  <= i_cfg_data;
                vtzc_pkg::REG_GRID_COLS:  r_grid_cols  <= i_cfg_data;
                vtzc_pkg::REG_ADJ_RADIUS: r_adj_radius <= i_cfg_data[vtzc_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated grid size and clamped radius.
    always_comb begin
        if (r_grid_rows < CNT_W'(2)) begin
            w_rows = CNT_W'(2);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            w_rows = CNT_W'(MAX_ROWS);
        end else begin
            w_rows = r_grid_rows;
        end
        if (r_grid_cols < CNT_W'(2)) begin
            w_cols = CNT_W'(2);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            w_cols = CNT_W'(MAX_COLS);
        end else begin
            w_cols = r_grid_cols;
        end
        w_lim = ((w_rows < w_cols) ? w_rows : w_cols) - CNT_W'(1);
        w_rad = (CNT_W'(r_adj_radius) > w_lim) ? w_lim[vtzc_pkg::RAD_W-1:0] : r_adj_radius;
    end

    // Angle magnitudes; the most negative code keeps its exact magnitude.
    assign w_pitch     = s_tdata[vtzc_pkg::PITCH_W-1:0];
    assign w_yaw       = s_tdata[vtzc_pkg::PITCH_W +: vtzc_pkg::YAW_W];
    assign w_pitch_mag = w_pitch[vtzc_pkg::PITCH_W-1]
                         ? (vtzc_pkg::MAG_W'(0) - vtzc_pkg::MAG_W'($signed(w_pitch)))
                         : vtzc_pkg::MAG_W'(w_pitch);
    assign w_yaw_mag   = w_yaw[vtzc_pkg::YAW_W-1]
                         ? (vtzc_pkg::MAG_W'(0) - vtzc_pkg::MAG_W'($signed(w_yaw)))
                         : vtzc_pkg::MAG_W'(w_yaw);
    assign w_pitch_pos = !w_pitch[vtzc_pkg::PITCH_W-1] && (w_pitch != '0);
    assign w_yaw_pos   = !w_yaw[vtzc_pkg::YAW_W-1] && (w_yaw != '0);

    assign s_tready   = (r_state == vtzc_pkg::ST_IDLE);
    assign w_in_acc   = s_tvalid && s_tready;
    assign w_out_free = !r_m_tvalid || m_tready;

    assign w_scan_last_col = (CNT_W'(r_scan_col) == w_cols - CNT_W'(1));
    assign w_scan_last_row = (CNT_W'(r_scan_row) == w_rows - CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_yaw_mag   = r_yaw_mag;
        n_pitch_pos = r_pitch_pos;
        n_yaw_pos   = r_yaw_pos;
        n_view_row  = r_view_row;
        n_view_col  = r_view_col;
        n_scan_row  = r_scan_row;
        n_scan_col  = r_scan_col;
        n_num       = r_num;
        n_m_tvalid  = r_m_tvalid && !m_tready;
        n_m_number  = r_m_number;
        n_m_zone    = r_m_zone;
        n_m_last    = r_m_last;
        w_div_start = 1'b0;
        w_div_mag   = w_pitch_mag;
        w_div_half  = w_rows[CNT_W-1:1];
        w_div_sel   = vtzc_pkg::SEL_PITCH;
        unique case (r_state)
            vtzc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    w_div_start = 1'b1;
                    n_yaw_mag   = w_yaw_mag;
                    n_pitch_pos = w_pitch_pos;
                    n_yaw_pos   = w_yaw_pos;
                    n_state     = vtzc_pkg::ST_PITCH;
                end
            end
            vtzc_pkg::ST_PITCH: begin
                w_div_mag  = r_yaw_mag;
                w_div_half = w_cols[CNT_W-1:1];
                w_div_sel  = vtzc_pkg::SEL_YAW;
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_view_row  = RW'(vtzc_pkg::grid_pos(w_div_quo, r_pitch_pos, w_rows));
                    n_state     = vtzc_pkg::ST_YAW;
                end
            end
            vtzc_pkg::ST_YAW: begin
                if (w_div_done) begin
                    n_view_col = CW'(vtzc_pkg::grid_pos(w_div_quo, r_yaw_pos, w_cols));
                    n_scan_row = '0;
                    n_scan_col = '0;
                    n_num      = '0;
                    n_state    = vtzc_pkg::ST_SCAN;
                end
            end
            vtzc_pkg::ST_SCAN: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_number = r_num + 1'b1;
                    n_num      = r_num + 1'b1;
                    n_m_zone   = vtzc_pkg::tile_zone(CNT_W'(r_scan_row), CNT_W'(r_scan_col),
                                                     CNT_W'(r_view_row), CNT_W'(r_view_col),
                                                     w_rows, w_cols, w_rad);
                    n_m_last   = w_scan_last_row && w_scan_last_col;
                    if (w_scan_last_col) begin
                        n_scan_col = '0;
                        n_scan_row = r_scan_row + 1'b1;
                    end else begin
                        n_scan_col = r_scan_col + 1'b1;
                    end
                    if (w_scan_last_row && w_scan_last_col) begin
                        n_scan_row = '0;
                        n_state    = vtzc_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = vtzc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vtzc_pkg::ST_IDLE;
            r_m_tvalid <= 1'b0;
            r_view_row <= '0;
            r_view_col <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
            r_view_row <= n_view_row;
            r_view_col <= n_view_col;
            r_scan_row <= n_scan_row;
            r_scan_col <= n_scan_col;
        end
        r_yaw_mag   <= n_yaw_mag;
        r_pitch_pos <= n_pitch_pos;
        r_yaw_pos   <= n_yaw_pos;
        r_num       <= n_num;
        r_m_number  <= n_m_number;
        r_m_zone    <= n_m_zone;
        r_m_last    <= n_m_last;
    end

    vtzc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (w_div_mag),
        .i_half  (w_div_half),
        .i_sel   (w_div_sel),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {7'd0, r_m_zone, r_m_number};
    assign m_tlast  = r_m_last;

    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == vtzc_pkg::ST_PITCH || r_state == vtzc_pkg::ST_YAW))
        else $error("divider finished outside a divide state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == vtzc_pkg::ST_PITCH))
        else $error("accepted orientation did not start the pitch division");

    a_view_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vtzc_pkg::ST_SCAN) |->
            (CNT_W'(r_view_row) < w_rows) && (CNT_W'(r_view_col) < w_cols))
        else $error("viewport tile outside the grid");

    a_scan_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vtzc_pkg::ST_SCAN) |->
            (CNT_W'(r_scan_row) < w_rows) && (CNT_W'(r_scan_col) < w_cols))
        else $error("scan pointer outside the grid");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vtzc_pkg::ST_SCAN) && w_out_free && w_scan_last_row && w_scan_last_col
            |=> (r_state == vtzc_pkg::ST_IDLE) && r_m_last)
        else $error("final tile did not end the scan");

endmodule

@@ verif/viewport_tile_zone_checker.sv @@
// Checker for the viewport tile zone classifier: watches the configuration,
// orientation and tile channels, predicts every tile and compares field by field.
// Depends on vtzc_pkg for register indexes, zone codes and angle steps.
module viewport_tile_zone_checker #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [13:0] pitch_angle, [28:14] yaw_angle
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [6:0] tile_number, [8:7] tile_zone
    input  logic        i_m_tlast,   // last_tile
    output int          o_fail_count,
    output int          o_tiles_pending
);

    typedef struct packed {
        logic [6:0] number;
        logic [1:0] zone;
        logic       last;
    } t_tile;

    t_tile      tiles_due[$];
    logic [3:0] rows_cfg;
    logic [3:0] cols_cfg;
    logic [1:0] radius_cfg;

    function automatic int clamp_count(input int v, input int maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // A positive angle counts up from index zero; zero and negative angles
    // count back from the last index.
    function automatic int grid_position(input int angle, input int count, input int step);
        int mag;
        int idx;
        mag = (angle < 0) ? -angle : angle;
        idx = mag * (count / 2) / step;
        if (angle > 0) return (idx >= count) ? count - 1 : idx;
        return (idx >= count - 1) ? 0 : count - 1 - idx;
    endfunction

    function automatic void scan_tiles(input logic [13:0] pitch, input logic [14:0] yaw);
        logic [1:0] zone_map [MAX_ROWS][MAX_COLS];
        int         rows;
        int         cols;
        int         rad;
        int         vr;
        int         vc;
        int         n;
        int         p;
        int         y;
        t_tile      t;
        rows = clamp_count(rows_cfg, MAX_ROWS);
        cols = clamp_count(cols_cfg, MAX_COLS);
        rad = radius_cfg;
        if (rad > ((rows < cols) ? rows : cols) - 1) rad = ((rows < cols) ? rows : cols) - 1;
        p = $signed(pitch);
        y = $signed(yaw);
        vr = grid_position(p, rows, int'(vtzc_pkg::PITCH_STEP));
        vc = grid_position(y, cols, int'(vtzc_pkg::YAW_STEP));
        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++)
                zone_map[r][c] = vtzc_pkg::ZONE_OUT;
        // Rays along the row, the column and both diagonals, wrapping around.
        for (int k = 1; k <= rad; k++)
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                    if (dr != 0 || dc != 0)
                        zone_map[(vr + rows + dr * k) % rows][(vc + cols + dc * k) % cols] =
                            vtzc_pkg::ZONE_ADJ;
        zone_map[vr][vc] = vtzc_pkg::ZONE_VIEW;
        n = 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                n++;
                t.number = 7'(n);
                t.zone = zone_map[r][c];
                t.last = (n == rows * cols);
                tiles_due.push_back(t);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        int    errs;
        t_tile want;
        errs = 0;
        if (!i_rst_n) begin
            rows_cfg = 4'd4;
            cols_cfg = 4'd8;
            radius_cfg = 2'd1;
            tiles_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vtzc_pkg::REG_GRID_ROWS: rows_cfg = i_cfg_data;
                    vtzc_pkg::REG_GRID_COLS: cols_cfg = i_cfg_data;
                    vtzc_pkg::REG_ADJ_RADIUS: radius_cfg = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                scan_tiles(i_s_tdata[13:0], i_s_tdata[28:14]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (tiles_due.size() == 0) begin
                    $error("tile_number: expected none, got %0d", i_m_tdata[6:0]);
                    errs++;
                end else begin
                    want = tiles_due.pop_front();
                    if (i_m_tdata[6:0] !== want.number) begin
                        $error("tile_number: expected %0d, got %0d", want.number,
                               i_m_tdata[6:0]);
                        errs++;
                    end
                    if (i_m_tdata[8:7] !== want.zone) begin
                        $error("tile_zone: expected %0d, got %0d", want.zone, i_m_tdata[8:7]);
                        errs++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_tile: expected %0d, got %0d", want.last, i_m_tlast);
                        errs++;
                    end
                end
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_tiles_pending <= tiles_due.size();
    end

endmodule

@@ verif/viewport_tile_zone_classifier_unit_tb.sv @@
// Testbench top for viewport_tile_zone_classifier_unit: drives orientations and
// register writes under several idle patterns and reports the verdict.
// Depends on vtzc_pkg, the block itself and viewport_tile_zone_checker.
module viewport_tile_zone_classifier_unit_tb;

    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SEGMENTS = 8;
    localparam int SEGMENT_ITEMS = 57;
    localparam int PITCH_SPAN = 6432;
    localparam int YAW_SPAN = 12864;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int tiles_pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    viewport_tile_zone_classifier_unit #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    viewport_tile_zone_checker #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_tiles_pending(tiles_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // The run is cut short when no transaction completes for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Leaves i_cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] index, input logic [3:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input int rows, input int cols, input int rad, input bit stray);
        write_reg(vtzc_pkg::REG_GRID_ROWS, 4'(rows));
        write_reg(vtzc_pkg::REG_GRID_COLS, 4'(cols));
        write_reg(vtzc_pkg::REG_ADJ_RADIUS, 4'(rad));
        if (stray) write_reg(REG_UNUSED, 4'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_orientation(input int pitch, input int yaw);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, 15'(yaw), 14'(pitch)};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // The pending count is a registered output of the checker, hence the first wait.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tiles_pending != 0) @(posedge i_clk);
    endtask

    // Mostly in-range angles, some near the ends, some anywhere in the field.
    function automatic int random_angle(input int span, input int width);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, (1 << width) - 1));
            1: return span * $urandom_range(0, 2) - span + $urandom_range(0, 2) - 1;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset grid of 4 by 8 with radius 1.
        send_orientation(0, 0);
        send_orientation(1, 1);
        send_orientation(-1, -1);
        send_orientation(6431, 12861);
        send_orientation(6432, 12864);
        send_orientation(-6432, -12864);
        send_orientation(-8192, -16384);
        send_orientation(8191, 16383);
        send_orientation(3215, 6430);
        send_orientation(3216, 6431);
        send_orientation(-3216, -6431);
        send_orientation(1608, -3215);
        wait_drained();
        // Saturated grid sizes and a radius larger than the grid allows.
        configure(0, 15, 3, 1'b0);
        send_orientation(-8192, 16383);
        send_orientation(6432, -1);
        wait_drained();
        // Full grid with no adjacency ring, plus a write to an unmapped index.
        configure(8, 8, 0, 1'b1);
        send_orientation(0, 0);
        send_orientation(4000, -9000);
        wait_drained();
        configure(8, 2, 3, 1'b0);
        send_orientation(-3000, 12000);
        wait_drained();
        configure(15, 1, 2, 1'b1);
        send_orientation(5000, -5000);
        wait_drained();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            case (seg)
                0: configure(8, 8, 3, 1'b0);
                1: configure(2, 2, 3, 1'b1);
                2: configure(15, 0, 0, 1'b0);
                default: configure($urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 3), $urandom_range(0, 2) == 0);
            endcase
            for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                send_orientation(random_angle(PITCH_SPAN, 14), random_angle(YAW_SPAN, 15));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/vtzc_pkg.sv
src/vtzc_div.sv
src/viewport_tile_zone_classifier_unit.sv
verif/viewport_tile_zone_checker.sv
verif/viewport_tile_zone_classifier_unit_tb.sv
